// ===== rtl/core/fpa_pkg.sv =====
// Shared types and constants for the fixed-point ALU with kept flags.
// Operation codes, request/response structs and stream packing widths.
// No dependencies.
`timescale 1ns / 1ps

package fpa_pkg;

    localparam int WORD_W    = 32;
    localparam int S_TDATA_W = 80;  // 75 payload bits padded to whole bytes
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 48;  // 43 payload bits padded to whole bytes

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_SHL     = 3'd1,
        OP_SHR     = 3'd2,
        OP_SRA     = 3'd3,
        OP_CMPS    = 3'd4,
        OP_CMPU    = 3'd5,
        OP_MUL     = 3'd6,
        OP_WRFLAGS = 3'd7
    } op_t;

    // add carry-in select; any other code uses the kept carry
    localparam logic [1:0] CIN_ZERO = 2'd0;
    localparam logic [1:0] CIN_ONE  = 2'd1;

    // condition field bits (SO is bit 0)
    localparam logic [3:0] COND_LT = 4'b1000;
    localparam logic [3:0] COND_GT = 4'b0100;
    localparam logic [3:0] COND_EQ = 4'b0010;

    localparam logic [2:0] CR0_INDEX = 3'd0;

    typedef struct packed {
        op_t                op;
        logic [WORD_W-1:0]  a;
        logic [WORD_W-1:0]  b;
        logic               invert_a;
        logic [1:0]         carry_mode;
        logic               set_carry;
        logic               set_overflow;
        logic               record_flags;
        logic [2:0]         field_index;
        logic               high_word;
        logic               signed_mul;
    } req_t;

    typedef struct packed {
        logic so;
        logic ov;
        logic ca;
    } flags_t;

    typedef struct packed {
        logic [WORD_W-1:0]  result;
        logic [3:0]         cond_value;
        logic               cond_write;
        logic [2:0]         cond_index;
    } rsp_t;

endpackage

// ===== rtl/core/fpa_exec.sv =====
// Combinational execute logic: add, shifts, compares, multiply, flag write.
// Produces the response and the updated flags for one request.
// Depends on fpa_pkg.
`timescale 1ns / 1ps

module fpa_exec
(
    input  fpa_pkg::req_t   req,
    input  fpa_pkg::flags_t flags_cur,
    output fpa_pkg::rsp_t   rsp,
    output fpa_pkg::flags_t flags_nxt
);
    import fpa_pkg::*;

    logic [WORD_W-1:0]   add_x;
    logic                add_cin;
    logic [WORD_W:0]     add_sum;
    logic                add_ov;
    logic [5:0]          shamt;
    logic [WORD_W-1:0]   shl_res;
    logic [WORD_W-1:0]   shr_res;
    logic [WORD_W-1:0]   sra_res;
    logic [WORD_W-1:0]   lost_mask;
    logic                sra_ca;
    logic signed [WORD_W:0]     mul_a;
    logic signed [WORD_W:0]     mul_b;
    logic signed [2*WORD_W+1:0] mul_full;
    logic [2*WORD_W-1:0] mul_prod;
    logic                mul_ov;
    logic                lt_s;
    logic                lt_u;
    logic                gt_s;
    logic                gt_u;
    logic [WORD_W-1:0]   res;
    logic                produces;
    logic [3:0]          cmp_cond;

    // add path
    assign add_x   = req.invert_a ? ~req.a : req.a;
    always_comb
    begin
        case (req.carry_mode)
            CIN_ZERO: add_cin = 1'b0;
            CIN_ONE:  add_cin = 1'b1;
            default:  add_cin = flags_cur.ca;
        endcase
    end
    assign add_sum = {1'b0, add_x} + {1'b0, req.b} + {{WORD_W{1'b0}}, add_cin};
    assign add_ov  = ~(add_x[WORD_W-1] ^ req.b[WORD_W-1])
                   & (add_x[WORD_W-1] ^ add_sum[WORD_W-1]);

    // shifts; amount is b[5:0], and 32 to 63 flushes the word
    assign shamt     = req.b[5:0];
    assign shl_res   = shamt[5] ? '0 : req.a << shamt[4:0];
    assign shr_res   = shamt[5] ? '0 : req.a >> shamt[4:0];
    assign sra_res   = shamt[5] ? {WORD_W{req.a[WORD_W-1]}}
                                : WORD_W'($signed(req.a) >>> shamt[4:0]);
    assign lost_mask = ~({WORD_W{1'b1}} << shamt[4:0]);
    assign sra_ca    = req.a[WORD_W-1] & (shamt[5] | (|(req.a & lost_mask)));

    // multiply: 33x33 signed covers both signed and unsigned forms
    assign mul_a    = {req.signed_mul & req.a[WORD_W-1], req.a};
    assign mul_b    = {req.signed_mul & req.b[WORD_W-1], req.b};
    assign mul_full = mul_a * mul_b;
    assign mul_prod = mul_full[2*WORD_W-1:0];
    assign mul_ov   = ~((&mul_prod[2*WORD_W-1:WORD_W-1])
                      | ~(|mul_prod[2*WORD_W-1:WORD_W-1]));

    // compares
    assign lt_s = $signed(req.a) < $signed(req.b);
    assign gt_s = $signed(req.a) > $signed(req.b);
    assign lt_u = req.a < req.b;
    assign gt_u = req.a > req.b;

    always_comb
    begin
        res       = '0;
        produces  = 1'b0;
        flags_nxt = flags_cur;
        cmp_cond  = '0;
        rsp       = '0;
        case (req.op)
            OP_ADD:
            begin
                res      = add_sum[WORD_W-1:0];
                produces = 1'b1;
                if (req.set_carry)
                    flags_nxt.ca = add_sum[WORD_W];
                if (req.set_overflow)
                begin
                    flags_nxt.ov = add_ov;
                    flags_nxt.so = flags_cur.so | add_ov;
                end
            end
            OP_SHL:
            begin
                res      = shl_res;
                produces = 1'b1;
            end
            OP_SHR:
            begin
                res      = shr_res;
                produces = 1'b1;
            end
            OP_SRA:
            begin
                res      = sra_res;
                produces = 1'b1;
                if (req.set_carry)
                    flags_nxt.ca = sra_ca;
            end
            OP_CMPS:
            begin
                cmp_cond = lt_s ? COND_LT : (gt_s ? COND_GT : COND_EQ);
            end
            OP_CMPU:
            begin
                cmp_cond = lt_u ? COND_LT : (gt_u ? COND_GT : COND_EQ);
            end
            OP_MUL:
            begin
                res      = req.high_word ? mul_prod[2*WORD_W-1:WORD_W]
                                         : mul_prod[WORD_W-1:0];
                produces = 1'b1;
                if (req.set_overflow)
                begin
                    flags_nxt.ov = mul_ov;
                    flags_nxt.so = flags_cur.so | mul_ov;
                end
            end
            OP_WRFLAGS:
            begin
                flags_nxt.so = req.a[WORD_W-1];
                flags_nxt.ov = req.a[WORD_W-2];
                flags_nxt.ca = req.a[WORD_W-3];
            end
            default:
            begin
                res = '0;
            end
        endcase

        rsp.result = res;
        if (req.op == OP_CMPS || req.op == OP_CMPU)
        begin
            rsp.cond_value = cmp_cond | {3'b000, flags_cur.so};
            rsp.cond_write = 1'b1;
            rsp.cond_index = req.field_index;
        end
        else if (produces && req.record_flags)
        begin
            // CR0 from the signed result, SO after this item's update
            rsp.cond_value = (res[WORD_W-1] ? COND_LT : ((|res) ? COND_GT : COND_EQ))
                           | {3'b000, flags_nxt.so};
            rsp.cond_write = 1'b1;
            rsp.cond_index = CR0_INDEX;
        end
    end

endmodule

// ===== rtl/core/fixed_point_alu_with_flags.sv =====
// Fixed-point ALU with kept carry, overflow and sticky summary-overflow flags.
// Path: an input transfer loads the input register; the item then moves to the
// result register and shows on m_axis once that stage is empty or draining.
// Throughput: one item per cycle unless m_axis stalls; flags from one item feed the
// next item directly from the flag registers, so dependent items run back to back.
// Reset (rst_n low, asynchronous): both stages empty, all flags cleared.
// Depends on fpa_pkg and fpa_exec.
`timescale 1ns / 1ps

module fixed_point_alu_with_flags
(
    input  logic                          clk,
    input  logic                          rst_n,
    // s_axis_tdata, low bit up: operand_a[31:0], operand_b[63:32],
    // invert_a[64], carry_mode[66:65], set_carry[67], set_overflow[68],
    // record_flags[69], field_index[72:70], high_word[73], signed_mul[74],
    // zero pad [79:75]
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [fpa_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // s_axis_tuser: req_type[2:0]
    input  logic [fpa_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // m_axis_tdata, low bit up: result[31:0], cond_value[35:32],
    // cond_write[36], cond_index[39:37], carry_flag[40], overflow_flag[41],
    // summary_flag[42], zero pad [47:43]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [fpa_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import fpa_pkg::*;

    // input stage
    logic   in_valid_reg;
    logic   in_valid_next;
    req_t   in_req_reg;
    req_t   s_req;

    // result stage
    logic   out_valid_reg;
    logic   out_valid_next;
    rsp_t   out_rsp_reg;
    flags_t out_flags_reg;

    // architectural flags
    flags_t flags_reg;
    flags_t flags_next;

    rsp_t   exec_rsp;
    flags_t exec_flags;

    logic   s_xfer;
    logic   advance;
    logic   issue;

    // unpack the incoming transfer
    assign s_req.op           = op_t'(s_axis_tuser);
    assign s_req.a            = s_axis_tdata[31:0];
    assign s_req.b            = s_axis_tdata[63:32];
    assign s_req.invert_a     = s_axis_tdata[64];
    assign s_req.carry_mode   = s_axis_tdata[66:65];
    assign s_req.set_carry    = s_axis_tdata[67];
    assign s_req.set_overflow = s_axis_tdata[68];
    assign s_req.record_flags = s_axis_tdata[69];
    assign s_req.field_index  = s_axis_tdata[72:70];
    assign s_req.high_word    = s_axis_tdata[73];
    assign s_req.signed_mul   = s_axis_tdata[74];

    // result stage can load when empty or being drained this cycle
    assign advance       = ~out_valid_reg | m_axis_tready;
    assign issue         = in_valid_reg & advance;
    assign s_axis_tready = ~in_valid_reg | advance;
    assign s_xfer        = s_axis_tvalid & s_axis_tready;

    fpa_exec u_exec
    (
        .req       (in_req_reg),
        .flags_cur (flags_reg),
        .rsp       (exec_rsp),
        .flags_nxt (exec_flags)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_xfer)
            in_valid_next = 1'b1;
        else if (issue)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = in_valid_reg;

        // flags commit as the item leaves the execute stage
        flags_next = issue ? exec_flags : flags_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            flags_reg     <= flags_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_xfer)
            in_req_reg <= s_req;
        if (issue)
        begin
            out_rsp_reg   <= exec_rsp;
            out_flags_reg <= exec_flags;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000,
                            out_flags_reg.so,
                            out_flags_reg.ov,
                            out_flags_reg.ca,
                            out_rsp_reg.cond_index,
                            out_rsp_reg.cond_write,
                            out_rsp_reg.cond_value,
                            out_rsp_reg.result};

endmodule

// ===== rtl/core/fpa_checker.sv =====
// Port-level checks for the fixed-point ALU, attached by bind.
// Depends on fpa_pkg and fixed_point_alu_with_flags.
`timescale 1ns / 1ps

module fpa_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [fpa_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import fpa_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // no condition write means an empty condition field
    a_cond_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[36]
            |-> m_axis_tdata[35:32] == 4'd0 && m_axis_tdata[39:37] == 3'd0)
        else $error("condition field set without write");

    // exactly one of LT/GT/EQ on a condition write
    a_cond_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[36] |-> $onehot(m_axis_tdata[35:33]))
        else $error("condition field not one-hot");

    // SO copy in the condition field matches the reported summary flag
    a_cond_so: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[36] |-> m_axis_tdata[32] == m_axis_tdata[42])
        else $error("condition SO differs from summary flag");

endmodule

bind fixed_point_alu_with_flags fpa_checker u_fpa_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
